// ===== hdl/sfp_pkg.sv =====
// sfp_pkg: shared constants for the serial frame parser
// phase codes, event codes, field widths and register map
// no dependencies
`default_nettype none

package sfp_pkg;

  localparam int unsigned MAX_PAYLOAD = 128;

  localparam int unsigned PHASE_W = 3;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [BYTE_W-1:0] HDR_BYTE        = 8'hFF;
  localparam logic [BYTE_W-1:0] DEVICE_ID_RESET = 8'h01;

  localparam logic [0:0] REG_DEVICE_ID = 1'b0;

  localparam logic [PHASE_W-1:0] PH_HUNT1 = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HUNT2 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ID    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LEN1  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LEN2  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_CHECK = 3'd6;

  localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DATA = 3'd1;
  localparam logic [EVENT_W-1:0] EV_GOOD = 3'd2;
  localparam logic [EVENT_W-1:0] EV_BAD  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LONG = 3'd4;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

endpackage

`default_nettype wire

// ===== hdl/serial_frame_parser.sv =====
// serial_frame_parser: length-prefixed frame parser with 8-bit additive checksum
// one byte a beat in, one result beat out; device id set over an apb-style port; uses sfp_pkg
// a byte's result appears in the output register in the cycle after the byte is taken
// throughput: one byte per cycle; the input stalls only while a held result is stalled
// reset: asynchronous, active low; hunting for the first header byte, sums and
// counters cleared, device id 1, no result pending
`default_nettype none

module serial_frame_parser (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sfp_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [sfp_pkg::DATA_W-1:0]       pwdata,
  output      logic [sfp_pkg::DATA_W-1:0]       prdata,
  output      logic                             pready,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [sfp_pkg::BYTE_W-1:0]       rx_byte_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [sfp_pkg::EVENT_W-1:0]      event_res_o,
  output      logic [sfp_pkg::BYTE_W-1:0]       payload_byte_o,
  output      logic [sfp_pkg::INDEX_W-1:0]      payload_index_o,
  output      logic [sfp_pkg::LEN_W-1:0]        frame_length_o
);

  logic [sfp_pkg::BYTE_W-1:0]  device_id_q;
  logic [sfp_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [sfp_pkg::BYTE_W-1:0]  sum_q, sum_d;
  logic [sfp_pkg::BYTE_W-1:0]  len_hi_q, len_hi_d;
  logic [sfp_pkg::LEN_W-1:0]   len_q, len_d;
  logic [sfp_pkg::COUNT_W-1:0] taken_q, taken_d;

  logic                        out_valid_q;
  logic [sfp_pkg::EVENT_W-1:0] ev_q, ev_d;
  logic [sfp_pkg::BYTE_W-1:0]  pbyte_q, pbyte_d;
  logic [sfp_pkg::INDEX_W-1:0] pidx_q, pidx_d;
  logic [sfp_pkg::LEN_W-1:0]   flen_q, flen_d;

  logic                        in_take;
  logic                        cfg_wr;
  logic [sfp_pkg::BYTE_W-1:0]  sum_add;
  logic [sfp_pkg::LEN_W-1:0]   len_new;
  logic [sfp_pkg::COUNT_W:0]   taken_next;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == sfp_pkg::REG_DEVICE_ID)
                  ? {{(sfp_pkg::DATA_W-sfp_pkg::BYTE_W){1'b0}}, device_id_q}
                  : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= sfp_pkg::DEVICE_ID_RESET;
    end else if (cfg_wr && paddr[2] == sfp_pkg::REG_DEVICE_ID) begin
      device_id_q <= pwdata[sfp_pkg::BYTE_W-1:0];
    end
  end

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  assign sum_add    = sum_q + rx_byte_i;
  assign len_new    = {len_hi_q, rx_byte_i};
  assign taken_next = {1'b0, taken_q} + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    len_hi_d = len_hi_q;
    len_d    = len_q;
    taken_d  = taken_q;
    ev_d     = sfp_pkg::EV_NONE;
    pbyte_d  = '0;
    pidx_d   = '0;
    flen_d   = '0;
    case (phase_q)
      sfp_pkg::PH_HUNT1: begin
        if (rx_byte_i == sfp_pkg::HDR_BYTE) begin
          phase_d = sfp_pkg::PH_HUNT2;
          sum_d   = '0;
          taken_d = '0;
        end
      end
      sfp_pkg::PH_HUNT2: begin
        phase_d = (rx_byte_i == sfp_pkg::HDR_BYTE) ? sfp_pkg::PH_ID : sfp_pkg::PH_HUNT1;
      end
      sfp_pkg::PH_ID: begin
        if (rx_byte_i == device_id_q) begin
          sum_d   = sum_add;
          phase_d = sfp_pkg::PH_LEN1;
        end else begin
          phase_d = sfp_pkg::PH_HUNT1;
        end
      end
      sfp_pkg::PH_LEN1: begin
        sum_d    = sum_add;
        len_hi_d = rx_byte_i;
        phase_d  = sfp_pkg::PH_LEN2;
      end
      sfp_pkg::PH_LEN2: begin
        sum_d   = sum_add;
        len_d   = len_new;
        taken_d = '0;
        if (len_new == '0) begin
          phase_d = sfp_pkg::PH_CHECK;
        end else if (len_new > sfp_pkg::MAX_LEN) begin
          ev_d    = sfp_pkg::EV_LONG;
          flen_d  = len_new;
          phase_d = sfp_pkg::PH_HUNT1;
        end else begin
          phase_d = sfp_pkg::PH_DATA;
        end
      end
      sfp_pkg::PH_DATA: begin
        sum_d   = sum_add;
        ev_d    = sfp_pkg::EV_DATA;
        pbyte_d = rx_byte_i;
        pidx_d  = taken_q[sfp_pkg::INDEX_W-1:0];
        flen_d  = len_q;
        if (sfp_pkg::LEN_W'(taken_next) >= len_q) begin
          phase_d = sfp_pkg::PH_CHECK;
        end
        taken_d = taken_next[sfp_pkg::COUNT_W-1:0];
      end
      sfp_pkg::PH_CHECK: begin
        ev_d    = (rx_byte_i == sum_q) ? sfp_pkg::EV_GOOD : sfp_pkg::EV_BAD;
        flen_d  = len_q;
        phase_d = sfp_pkg::PH_HUNT1;
      end
      default: begin
        phase_d = sfp_pkg::PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sfp_pkg::PH_HUNT1;
      sum_q    <= '0;
      len_hi_q <= '0;
      len_q    <= '0;
      taken_q  <= '0;
    end else if (in_take) begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      len_hi_q <= len_hi_d;
      len_q    <= len_d;
      taken_q  <= taken_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ev_q    <= ev_d;
      pbyte_q <= pbyte_d;
      pidx_q  <= pidx_d;
      flen_q  <= flen_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = ev_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign frame_length_o  = flen_q;

endmodule

`default_nettype wire

// ===== hdl/sfp_checker.sv =====
// sfp_checker: port-level assertions for serial_frame_parser, bound into each of its instances
// depends on sfp_pkg and serial_frame_parser
`default_nettype none

module sfp_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [sfp_pkg::EVENT_W-1:0] event_res_o,
  input wire logic [sfp_pkg::BYTE_W-1:0]  payload_byte_o,
  input wire logic [sfp_pkg::INDEX_W-1:0] payload_index_o,
  input wire logic [sfp_pkg::LEN_W-1:0]   frame_length_o
);

  // held result beat stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o)
      && $stable(payload_byte_o) && $stable(frame_length_o))
    else $error("stalled result changed");

  // no new byte while the result register is full and stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while result stalled");

  // only payload beats carry byte and index
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != sfp_pkg::EV_DATA
      |-> payload_byte_o == '0 && payload_index_o == '0)
    else $error("payload fields set outside a payload beat");

  // payload index lies inside the declared length
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == sfp_pkg::EV_DATA
      |-> sfp_pkg::LEN_W'(payload_index_o) < frame_length_o
        && frame_length_o <= sfp_pkg::MAX_LEN)
    else $error("payload index beyond frame length");

endmodule

bind serial_frame_parser sfp_checker u_sfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .event_res_o     (event_res_o),
  .payload_byte_o  (payload_byte_o),
  .payload_index_o (payload_index_o),
  .frame_length_o  (frame_length_o)
);

`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking bench for serial_frame_parser, byte stream in, one result beat per byte
// directed frame table then random framed traffic over six device ids, checked by a predictor
// depends on sfp_pkg and serial_frame_parser
module tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 60;
  localparam int PHASE_ITEMS    = 312;
  localparam int REPORT_CAP     = 50;

  typedef struct packed {
    logic [sfp_pkg::EVENT_W-1:0] ev;
    logic [sfp_pkg::BYTE_W-1:0]  data;
    logic [sfp_pkg::INDEX_W-1:0] idx;
    logic [sfp_pkg::LEN_W-1:0]   len;
  } parse_result_t;

  typedef struct packed {
    logic [sfp_pkg::BYTE_W-1:0] rx;
    logic                       typed;
    parse_result_t              res;
  } frame_row_t;

  localparam parse_result_t NO_EVENT = '{sfp_pkg::EV_NONE, 8'h00, 7'h00, 16'h0000};

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [sfp_pkg::ADDR_W-1:0] paddr;
  logic [sfp_pkg::DATA_W-1:0] pwdata, prdata;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [sfp_pkg::BYTE_W-1:0]  rx_byte_i, payload_byte_o;
  logic [sfp_pkg::EVENT_W-1:0] event_res_o;
  logic [sfp_pkg::INDEX_W-1:0] payload_index_o;
  logic [sfp_pkg::LEN_W-1:0]   frame_length_o;

  // predictor state
  logic [sfp_pkg::PHASE_W-1:0] phase_q;
  logic [sfp_pkg::BYTE_W-1:0]  sum_q, len_hi_q, taken_q, dev_id_q;
  logic [sfp_pkg::LEN_W-1:0]   len_q;

  parse_result_t expected_q[$];
  parse_result_t row_exp;
  logic          row_typed;

  int fail_count, quiet_cycles, items_sent, results_seen;
  int data_beats, good_frames, bad_frames, long_frames, id_writes;
  bit gap_mode, stall_mode, hold_req;
  int hold_left, stall_run;

  frame_row_t frame_rows [24] = '{
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'h00, 1'b1, NO_EVENT},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'h02, 1'b1, NO_EVENT},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'h01, 1'b1, NO_EVENT},
    '{8'h00, 1'b1, NO_EVENT},
    '{8'h00, 1'b1, NO_EVENT},
    '{8'h01, 1'b1, '{sfp_pkg::EV_GOOD, 8'h00, 7'h00, 16'h0000}},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'h01, 1'b1, NO_EVENT},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'hFF, 1'b1, '{sfp_pkg::EV_LONG, 8'h00, 7'h00, 16'hFFFF}},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'h01, 1'b1, NO_EVENT},
    '{8'h00, 1'b1, NO_EVENT},
    '{8'h02, 1'b1, NO_EVENT},
    '{8'h00, 1'b0, NO_EVENT},
    '{8'hFF, 1'b0, NO_EVENT},
    '{8'h03, 1'b1, '{sfp_pkg::EV_BAD, 8'h00, 7'h00, 16'h0002}}
  };

  serial_frame_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_res_o     (event_res_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .frame_length_o  (frame_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic parse_result_t parse_rx_byte(input logic [sfp_pkg::BYTE_W-1:0] b);
    parse_result_t r;
    r = NO_EVENT;
    case (phase_q)
      sfp_pkg::PH_HUNT1: if (b == sfp_pkg::HDR_BYTE) begin
        phase_q = sfp_pkg::PH_HUNT2;
        sum_q = '0;
        taken_q = '0;
      end
      sfp_pkg::PH_HUNT2: phase_q = (b == sfp_pkg::HDR_BYTE) ? sfp_pkg::PH_ID : sfp_pkg::PH_HUNT1;
      sfp_pkg::PH_ID: if (b == dev_id_q) begin
        sum_q += b;
        phase_q = sfp_pkg::PH_LEN1;
      end else begin
        phase_q = sfp_pkg::PH_HUNT1;
      end
      sfp_pkg::PH_LEN1: begin
        sum_q += b;
        len_hi_q = b;
        phase_q = sfp_pkg::PH_LEN2;
      end
      sfp_pkg::PH_LEN2: begin
        sum_q += b;
        len_q = {len_hi_q, b};
        taken_q = '0;
        if (len_q == '0) begin
          phase_q = sfp_pkg::PH_CHECK;
        end else if (len_q > sfp_pkg::MAX_LEN) begin
          r.ev = sfp_pkg::EV_LONG;
          r.len = len_q;
          phase_q = sfp_pkg::PH_HUNT1;
        end else begin
          phase_q = sfp_pkg::PH_DATA;
        end
      end
      sfp_pkg::PH_DATA: begin
        sum_q += b;
        r.ev = sfp_pkg::EV_DATA;
        r.data = b;
        r.idx = taken_q[sfp_pkg::INDEX_W-1:0];
        r.len = len_q;
        if ({8'h00, taken_q} + 16'd1 >= len_q) phase_q = sfp_pkg::PH_CHECK;
        taken_q += 8'd1;
      end
      sfp_pkg::PH_CHECK: begin
        r.ev = (b == sum_q) ? sfp_pkg::EV_GOOD : sfp_pkg::EV_BAD;
        r.len = len_q;
        phase_q = sfp_pkg::PH_HUNT1;
      end
      default: phase_q = sfp_pkg::PH_HUNT1;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [sfp_pkg::LEN_W-1:0] want,
                             input logic [sfp_pkg::LEN_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_CAP) $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // input prediction and output checking
  always @(posedge clk_i) begin
    parse_result_t pred, want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        pred = parse_rx_byte(rx_byte_i);
        expected_q.push_back(row_typed ? row_exp : pred);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        results_seen++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP) $error("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          check_field("event_res", sfp_pkg::LEN_W'(want.ev), sfp_pkg::LEN_W'(event_res_o));
          check_field("payload_byte", sfp_pkg::LEN_W'(want.data),
                      sfp_pkg::LEN_W'(payload_byte_o));
          check_field("payload_index", sfp_pkg::LEN_W'(want.idx),
                      sfp_pkg::LEN_W'(payload_index_o));
          check_field("frame_length", want.len, frame_length_o);
          case (want.ev)
            sfp_pkg::EV_DATA: data_beats++;
            sfp_pkg::EV_GOOD: good_frames++;
            sfp_pkg::EV_BAD:  bad_frames++;
            sfp_pkg::EV_LONG: long_frames++;
            default: ;
          endcase
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // receiver: random stall runs, plus one long hold-off on request
  initial begin
    int unsigned roll;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      roll = $urandom_range(0, 99);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (!stall_mode) begin
        out_stall_i <= 1'b0;
      end else if (stall_run > 0) begin
        out_stall_i <= 1'b1;
        stall_run--;
      end else if (roll < 60) begin
        out_stall_i <= 1'b0;
      end else if (roll < 93) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(10, 30);
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("serial_frame_parser: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!gap_mode || roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 2);
    if (roll < 98) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [sfp_pkg::BYTE_W-1:0] b, input logic typed,
                           input parse_result_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      rx_byte_i <= sfp_pkg::BYTE_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    row_typed <= typed;
    row_exp <= res;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_device_id(input logic [sfp_pkg::BYTE_W-1:0] id);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= sfp_pkg::ADDR_W'(4 * sfp_pkg::REG_DEVICE_ID);
    pwdata <= {24'($urandom), id};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    dev_id_q = id;
    id_writes++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [sfp_pkg::BYTE_W-1:0] pick_payload();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return sfp_pkg::HDR_BYTE;
    if (roll < 20) return 8'h00;
    return sfp_pkg::BYTE_W'($urandom);
  endfunction

  // mostly well-formed frames with random content, the rest broken or noise
  task automatic send_random_frame();
    logic [sfp_pkg::BYTE_W-1:0] frame_q[$];
    logic [sfp_pkg::BYTE_W-1:0] sum, b;
    logic [sfp_pkg::LEN_W-1:0]  len;
    int unsigned kind, roll;
    int cut;
    kind = $urandom_range(0, 99);
    roll = $urandom_range(0, 99);
    if (kind >= 95) begin
      repeat ($urandom_range(1, 6)) frame_q.push_back(sfp_pkg::BYTE_W'($urandom));
    end else if (kind >= 90) begin
      frame_q = {sfp_pkg::HDR_BYTE, sfp_pkg::BYTE_W'($urandom_range(0, 254))};
    end else if (kind >= 83) begin
      frame_q = {sfp_pkg::HDR_BYTE, sfp_pkg::HDR_BYTE,
                 dev_id_q ^ sfp_pkg::BYTE_W'($urandom_range(1, 255))};
    end else begin
      if (kind >= 76) begin
        if (roll < 30) len = sfp_pkg::MAX_LEN + 16'd1;
        else if (roll < 45) len = 16'hFFFF;
        else if (roll < 55) len = 16'h0100;
        else len = sfp_pkg::LEN_W'($urandom_range(sfp_pkg::MAX_PAYLOAD + 1, 65535));
      end else begin
        if (roll < 10) len = '0;
        else if (roll < 70) len = sfp_pkg::LEN_W'($urandom_range(1, 8));
        else if (roll < 85) len = sfp_pkg::LEN_W'($urandom_range(9, 32));
        else if (roll < 95) len = sfp_pkg::LEN_W'($urandom_range(33, sfp_pkg::MAX_PAYLOAD - 1));
        else len = sfp_pkg::MAX_LEN;
      end
      sum = dev_id_q + len[15:8] + len[7:0];
      frame_q = {sfp_pkg::HDR_BYTE, sfp_pkg::HDR_BYTE, dev_id_q, len[15:8], len[7:0]};
      if (len <= sfp_pkg::MAX_LEN) begin
        for (int i = 0; i < int'(len); i++) begin
          b = pick_payload();
          sum += b;
          frame_q.push_back(b);
        end
        if (kind >= 55 && kind < 63) sum ^= sfp_pkg::BYTE_W'($urandom_range(1, 255));
        frame_q.push_back(sum);
        if (kind >= 63 && kind < 68) begin
          cut = $urandom_range(1, frame_q.size() - 1);
          frame_q = frame_q[0:cut-1];
        end
      end
    end
    foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, NO_EVENT);
  endtask

  initial begin
    logic [sfp_pkg::BYTE_W-1:0] id_list [6];
    int phase_end;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    row_typed = 1'b0;
    row_exp = NO_EVENT;
    phase_q = sfp_pkg::PH_HUNT1;
    sum_q = '0;
    len_hi_q = '0;
    len_q = '0;
    taken_q = '0;
    dev_id_q = sfp_pkg::DEVICE_ID_RESET;
    gap_mode = 1'b1;
    stall_mode = 1'b1;
    id_list = '{8'hFF, 8'h00, sfp_pkg::BYTE_W'($urandom), 8'h01,
                sfp_pkg::BYTE_W'($urandom_range(2, 254)), 8'h80};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (frame_rows[i]) send_byte(frame_rows[i].rx, frame_rows[i].typed, frame_rows[i].res);

    foreach (id_list[p]) begin
      wait_drained();
      write_device_id(id_list[p]);
      gap_mode = (p != 0) && (p != 2);
      stall_mode = (p != 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (p == 2 && items_sent >= phase_end - PHASE_ITEMS / 2 && !hold_req
            && hold_left == 0 && stall_mode) begin
          // back-pressure: receiver holds off while bytes keep coming
          hold_req = 1'b1;
          stall_mode = 1'b0;
        end
        if (p == 3 && items_sent >= phase_end - PHASE_ITEMS / 2 && gap_mode) begin
          wait_drained();
          gap_mode = 1'b0;
        end
        send_random_frame();
      end
    end
    wait_drained();
    repeat (4) @(negedge clk_i);

    $display("covered %0d bytes, %0d results over %0d device id writes incl 0x00 and 0xff",
             items_sent, results_seen, id_writes);
    $display("%0d payload beats, %0d good, %0d bad checksum, %0d oversize frames",
             data_beats, good_frames, bad_frames, long_frames);
    if (fail_count == 0) begin
      $display("serial_frame_parser: match");
    end else begin
      $display("serial_frame_parser: mismatch");
    end
    $finish;
  end

endmodule
